### rtl/qrt_pkg.sv
package qrt_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 4;
  localparam int unsigned TICK_WIDTH_DEF = 16;
  localparam int unsigned TIMER_IDX_W    = 2;
  localparam int unsigned MAX_TIMERS     = 4;

  localparam logic [7:0]  CTRL_MASK   = 8'h8c;
  localparam int unsigned CTRL_EN_BIT = 7;
  localparam logic [31:0] LOAD_RESET  = 32'hffff_ffff;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [1:0] BANK_CTRL  = 2'd0;
  localparam logic [1:0] BANK_LOAD  = 2'd1;
  localparam logic [1:0] BANK_COUNT = 2'd2;
  localparam logic [1:0] BANK_CLEAR = 2'd3;

  localparam logic [1:0] PRE_DIV16  = 2'd1;
  localparam logic [1:0] PRE_DIV256 = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_WRITE,
    OP_TICK
  } op_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t         op;
    logic [1:0]  bank;
    logic [1:0]  timer;
    logic [31:0] wdata;
    logic [31:0] ticks;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_CHECK,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

### rtl/qrt_front.sv
module qrt_front import qrt_pkg::*; #(
  parameter int unsigned NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int unsigned TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [5:0]            in_reg_offset,
  input  logic [31:0]           in_write_value,
  input  logic [TICK_WIDTH-1:0] in_tick_count,
  output logic                  q_valid,
  input  logic                  q_pop,
  output req_t                  q_req
);

  // two-entry queue
  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  req_t       cls;
  logic       mapped;
  logic       push;

  always_comb begin
    mapped = (in_reg_offset[1:0] == 2'b00) &&
             ({1'b0, in_reg_offset[3:2]} < (TIMER_IDX_W+1)'(NUM_TIMERS));
    cls.bank  = in_reg_offset[5:4];
    cls.timer = in_reg_offset[3:2];
    cls.wdata = in_write_value;
    cls.ticks = 32'(in_tick_count);
    if (in_action == ACT_TICK)
      cls.op = OP_TICK;
    else if (in_action == ACT_READ && mapped)
      cls.op = OP_READ;
    else if (in_action == ACT_WRITE && mapped)
      cls.op = OP_WRITE;
    else
      cls.op = OP_NONE;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop && q_valid);
    end
  end

endmodule

### rtl/qrt_div.sv
module qrt_div import qrt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [32:0] rem
);

  // restoring remainder, one quotient bit a cycle
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvd_r;
  logic [32:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [33:0] trial;

  always_comb begin
    trial   = {rem_r, dvd_r[31]} - {1'b0, dvs_r};
    rem_nxt = trial[33] ? {rem_r[31:0], dvd_r[31]} : trial[32:0];
  end

  assign rem  = rem_r;
  assign done = busy_r && (cnt_r == 6'd0);

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r && cnt_r != 6'd0) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

endmodule

### rtl/qrt_back.sv
module qrt_back import qrt_pkg::*; #(
  parameter int unsigned NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  req_t        q_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic [3:0]  out_irq_lines
);

  logic [7:0]  ctrl_r   [MAX_TIMERS];
  logic [31:0] load_r   [MAX_TIMERS];
  logic [31:0] count_r  [MAX_TIMERS];
  logic [7:0]  rem_r    [MAX_TIMERS];
  logic [MAX_TIMERS-1:0] irq_r;

  state_t state_r, state_nxt;
  req_t   req_r;
  logic [TIMER_IDX_W:0] t_r;
  logic [TIMER_IDX_W-1:0] ti;
  logic [32:0] n_r;      // prescaled ticks (divided by 16 or 256, or undivided)
  logic [31:0] cnt_eff_r;
  logic [31:0] rdata_r;

  logic        div_start, div_done;
  logic [32:0] div_rem;
  logic [32:0] sum;
  logic [1:0]  sel;
  logic        t_last;
  logic        t_en;

  assign ti     = t_r[TIMER_IDX_W-1:0];
  assign sel    = ctrl_r[ti][3:2];
  assign sum    = req_r.ticks + 33'(rem_r[ti]);
  assign t_last = (t_r == (TIMER_IDX_W+1)'(NUM_TIMERS - 1));
  assign t_en   = ctrl_r[ti][CTRL_EN_BIT];

  qrt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r[31:0] - cnt_eff_r),
    .divisor  ({1'b0, load_r[ti]} + 33'd1),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = (q_req.op == OP_TICK) ? ST_PICK : ST_OUT;
      ST_PICK:  state_nxt = t_en ? ST_CHECK : (t_last ? ST_OUT : ST_PICK);
      ST_CHECK: state_nxt = (n_r < {1'b0, cnt_eff_r}) ? ST_FIN : ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_FIN;
      ST_FIN:   state_nxt = t_last ? ST_OUT : ST_PICK;
      ST_OUT:   if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == ST_IDLE) && q_valid;
    div_start = (state_r == ST_CHECK) && !(n_r < {1'b0, cnt_eff_r});
    out_valid = (state_r == ST_OUT);
  end

  assign out_read_data = rdata_r;
  always_comb begin
    out_irq_lines = '0;
    for (int i = 0; i < NUM_TIMERS; i++) out_irq_lines[i] = irq_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < MAX_TIMERS; i++) begin
        ctrl_r[i]  <= '0;
        load_r[i]  <= LOAD_RESET;
        count_r[i] <= '0;
        rem_r[i]   <= '0;
      end
      irq_r <= '0;
      t_r   <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: if (q_valid) begin
          req_r <= q_req;
          t_r   <= '0;
          if (q_req.op == OP_READ) begin
            case (q_req.bank)
              BANK_CTRL:  rdata_r <= 32'(ctrl_r[q_req.timer]);
              BANK_LOAD:  rdata_r <= load_r[q_req.timer];
              BANK_COUNT: rdata_r <= count_r[q_req.timer];
              default:    rdata_r <= '0;
            endcase
          end else begin
            rdata_r <= '0;
          end
          if (q_req.op == OP_WRITE) begin
            case (q_req.bank)
              BANK_CTRL:  ctrl_r[q_req.timer] <= q_req.wdata[7:0] & CTRL_MASK;
              BANK_LOAD: begin
                load_r[q_req.timer]  <= q_req.wdata;
                count_r[q_req.timer] <= q_req.wdata;
              end
              BANK_CLEAR: irq_r[q_req.timer] <= 1'b0;
              default: ;
            endcase
          end
        end
        ST_PICK: begin
          if (t_en) begin
            cnt_eff_r <= (count_r[ti] == 32'd0) ? load_r[ti] : count_r[ti];
            if (sel == PRE_DIV16) begin
              n_r       <= 33'(sum[32:4]);
              rem_r[ti] <= {4'd0, sum[3:0]};
            end else if (sel == PRE_DIV256) begin
              n_r       <= 33'(sum[32:8]);
              rem_r[ti] <= sum[7:0];
            end else begin
              n_r <= {1'b0, req_r.ticks};
            end
          end else if (!t_last) begin
            t_r <= t_r + 1'b1;
          end
        end
        ST_CHECK: if (n_r < {1'b0, cnt_eff_r}) count_r[ti] <= cnt_eff_r - n_r[31:0];
        ST_DIV: if (div_done) begin
          count_r[ti] <= load_r[ti] - div_rem[31:0];
          irq_r[ti]   <= 1'b1;
        end
        ST_FIN: if (!t_last) t_r <= t_r + 1'b1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/quad_reload_timer_with_prescaler_top.sv
// Four down-counting reload timers behind a request/result port. Each request
// (read, write or tick advance) gives one result carrying read data and the
// interrupt levels. Reads and writes are picked up and then presented by the
// back end. A tick advance walks the timers one at a time: a disabled timer is
// skipped, one that does not reach its terminal count is stepped directly, and
// one that does uses the shared serial remainder unit. A two-entry queue
// decouples acceptance.
module quad_reload_timer_with_prescaler_top import qrt_pkg::*; #(
  parameter int unsigned NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int unsigned TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [5:0]            in_reg_offset,
  input  logic [31:0]           in_write_value,
  input  logic [TICK_WIDTH-1:0] in_tick_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_read_data,
  output logic [3:0]            out_irq_lines
);

  logic q_valid, q_pop;
  req_t q_req;

  qrt_front #(.NUM_TIMERS(NUM_TIMERS), .TICK_WIDTH(TICK_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_reg_offset,
    .in_write_value, .in_tick_count, .q_valid, .q_pop, .q_req
  );

  qrt_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_req, .out_valid, .out_ready,
    .out_read_data, .out_irq_lines
  );

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import qrt_pkg::*;

  typedef struct {
    logic [31:0] rdata;
    logic [3:0]  irq;
  } timer_res_t;

  class timer_scoreboard;
    logic [7:0]  ctrl[4];
    logic [31:0] load[4];
    logic [31:0] cnt[4];
    logic [7:0]  rem[4];
    logic        irq[4];
    timer_res_t  pending[$];
    int          errors;

    function new();
      for (int i = 0; i < 4; i++) begin
        ctrl[i] = '0;
        load[i] = '1;
        cnt[i] = '0;
        rem[i] = '0;
        irq[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function void step_timer(int t, logic [63:0] n);
      logic [63:0] c;
      logic [63:0] l;
      l = {32'd0, load[t]};
      if (cnt[t] == 0) cnt[t] = load[t];
      c = {32'd0, cnt[t]};
      if (n < c) begin
        cnt[t] = 32'(c - n);
      end else begin
        n = (n - c) % (l + 64'd1);
        cnt[t] = 32'(l - n);
        irq[t] = 1'b1;
      end
    endfunction

    function void note_request(logic [1:0] act, logic [5:0] off, logic [31:0] wv,
                               logic [15:0] ticks);
      timer_res_t r;
      logic [1:0]  bank;
      int          t;
      logic [63:0] n;
      logic [1:0]  sel;
      bank = off[5:4];
      t = int'(off[3:2]);
      r.rdata = '0;
      r.irq = '0;
      if (act == ACT_READ && off[1:0] == 2'b00) begin
        case (bank)
          BANK_CTRL: r.rdata = {24'd0, ctrl[t]};
          BANK_LOAD: r.rdata = load[t];
          BANK_COUNT: r.rdata = cnt[t];
          default: r.rdata = '0;
        endcase
      end else if (act == ACT_WRITE && off[1:0] == 2'b00) begin
        case (bank)
          BANK_CTRL: ctrl[t] = wv[7:0] & CTRL_MASK;
          BANK_LOAD: begin
            load[t] = wv;
            cnt[t] = wv;
          end
          BANK_CLEAR: irq[t] = 1'b0;
          default: ;
        endcase
      end else if (act == ACT_TICK) begin
        for (int i = 0; i < 4; i++) begin
          if (ctrl[i][CTRL_EN_BIT]) begin
            sel = ctrl[i][3:2];
            n = {48'd0, ticks} + {56'd0, rem[i]};
            if (sel == PRE_DIV16) begin
              rem[i] = 8'(n % 64'd16);
              step_timer(i, n / 64'd16);
            end else if (sel == PRE_DIV256) begin
              rem[i] = 8'(n % 64'd256);
              step_timer(i, n / 64'd256);
            end else begin
              step_timer(i, {48'd0, ticks});
            end
          end
        end
      end
      for (int i = 0; i < 4; i++) r.irq[i] = irq[i];
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] rdata, logic [3:0] irql);
      timer_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result rdata=%h irq=%h", $time, rdata, irql);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (rdata !== e.rdata) begin
        $display("%0t: read_data expected %h actual %h", $time, e.rdata, rdata);
        errors++;
      end
      if (irql !== e.irq) begin
        $display("%0t: irq_lines expected %h actual %h", $time, e.irq, irql);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [5:0]  in_reg_offset;
  logic [31:0] in_write_value;
  logic [15:0] in_tick_count;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_read_data;
  logic [3:0]  out_irq_lines;

  timer_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  longint cycles;

  quad_reload_timer_with_prescaler_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_reg_offset(in_reg_offset),
    .in_write_value(in_write_value), .in_tick_count(in_tick_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_data(out_read_data), .out_irq_lines(out_irq_lines)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // timeout watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side: random back-pressure and checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_read_data, out_irq_lines);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // valid is only dropped when the sender idles or drains
  task automatic send_request(logic [1:0] act, logic [5:0] off, logic [31:0] wv,
                              logic [15:0] ticks);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_reg_offset <= off;
    in_write_value <= wv;
    in_tick_count <= ticks;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(act, off, wv, ticks);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // register offsets: bank in 5:4, timer in 3:2
  function automatic logic [5:0] reg_at(logic [1:0] bank, int t);
    return {bank, t[1:0], 2'b00};
  endfunction

  task automatic random_request();
    int k;
    int t;
    logic [31:0] wv;
    k = $urandom_range(99);
    t = $urandom_range(3);
    if (k < 35) begin
      send_request(ACT_TICK, 6'($urandom), $urandom,
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40)));
    end else if (k < 55) begin
      send_request(ACT_READ, reg_at(2'($urandom_range(3)), t), $urandom, 16'($urandom));
    end else if (k < 65) begin
      wv = $urandom;
      wv[CTRL_EN_BIT] = 1'($urandom_range(1));
      send_request(ACT_WRITE, reg_at(BANK_CTRL, t), wv, 16'($urandom));
    end else if (k < 77) begin
      case ($urandom_range(3))
        0: wv = 32'd0;
        1: wv = 32'hffff_ffff;
        2: wv = $urandom;
        default: wv = $urandom_range(60);
      endcase
      send_request(ACT_WRITE, reg_at(BANK_LOAD, t), wv, 16'($urandom));
    end else if (k < 87) begin
      send_request(ACT_WRITE, reg_at(BANK_CLEAR, t), $urandom, 16'($urandom));
    end else if (k < 93) begin
      send_request(ACT_WRITE, reg_at(BANK_COUNT, t), $urandom, 16'($urandom));
    end else begin
      // noise: random action and offset, including unaligned offsets and action 3
      send_request(2'($urandom), 6'($urandom), $urandom, 16'($urandom));
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = '0;
    in_reg_offset = '0;
    in_write_value = '0;
    in_tick_count = '0;
    out_ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    send_request(ACT_READ, reg_at(BANK_LOAD, 0), '0, '0);
    send_request(ACT_WRITE, reg_at(BANK_CTRL, 0), 32'hffff_ffff, '0);
    send_request(ACT_READ, reg_at(BANK_CTRL, 0), '0, '0);
    send_request(ACT_WRITE, reg_at(BANK_LOAD, 0), 32'd0, '0);
    send_request(ACT_TICK, '0, '0, 16'd0);       // zero load and count still fires
    send_request(ACT_WRITE, reg_at(BANK_CLEAR, 0), '0, '0);
    send_request(ACT_WRITE, reg_at(BANK_CTRL, 1), 32'h84, '0);
    send_request(ACT_WRITE, reg_at(BANK_LOAD, 1), 32'd5, '0);
    send_request(ACT_TICK, '0, '0, 16'hffff);
    send_request(ACT_WRITE, reg_at(BANK_CTRL, 1), 32'h88, '0); // remainder carried over
    send_request(ACT_TICK, '0, '0, 16'd300);
    send_request(ACT_WRITE, reg_at(BANK_CTRL, 2), 32'h8c, '0);
    send_request(ACT_WRITE, reg_at(BANK_LOAD, 2), 32'hffff_ffff, '0);
    send_request(ACT_TICK, '0, '0, 16'hffff);
    send_request(ACT_READ, reg_at(BANK_COUNT, 2), '0, '0);
    send_request(ACT_READ, reg_at(BANK_CLEAR, 1), '0, '0);
    send_request(ACT_WRITE, reg_at(BANK_COUNT, 1), 32'h1234, '0);
    send_request(ACT_READ, 6'h15, '0, '0);
    send_request(ACT_WRITE, 6'h13, 32'hffff_ffff, '0);
    send_request(2'd3, reg_at(BANK_LOAD, 3), 32'h55, 16'h55);
    send_request(ACT_READ, reg_at(BANK_COUNT, 1), 32'hffff_ffff, 16'hffff);
    drain();

    send_idle_pct = 36;
    recv_idle_pct = 67;
    repeat (230) random_request();
    drain();  // sender holds off until all results are in
    send_idle_pct = 67;
    recv_idle_pct = 36;
    repeat (230) random_request();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (240) random_request();
    drain();
    repeat (200) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
